@@ rtl/ppd_pkg.sv @@
package ppd_pkg;

	localparam int WinDepth = 9;
	localparam int SumBytes = 8;
	localparam int MagW     = 28;
	localparam int DivW     = 15;
	localparam int OutW     = 18;
	localparam int CntW     = $clog2(MagW + 1);

	localparam logic [7:0] HDR_FIRST  = 8'h5E;
	localparam logic [7:0] HDR_SECOND = 8'h0C;

	localparam logic [2:0] CFG_SPAN_X        = 3'd0;
	localparam logic [2:0] CFG_SPAN_Y        = 3'd1;
	localparam logic [2:0] CFG_AREA_X        = 3'd2;
	localparam logic [2:0] CFG_AREA_Y        = 3'd3;
	localparam logic [2:0] CFG_BORDER_GAP    = 3'd4;
	localparam logic [2:0] CFG_REPLY_CODE    = 3'd5;
	localparam logic [2:0] CFG_POSITION_CODE = 3'd6;

	typedef logic [7:0]      byte_t;
	typedef logic [MagW-1:0] mag_t;
	typedef logic [DivW-1:0] dvs_t;

endpackage

@@ rtl/position_packet_deframer.sv @@
// position packet deframer: received link bytes enter one beat at a time and
// shift through a row of nine byte cells; together with the new byte they form
// a ten-byte window that is checked on every beat for header 5E 0C and a
// big-endian 16-bit sum over its first eight bytes in bytes 8 and 9. a good
// frame whose command byte matches reply_code gives a reply beat (kind 0, zero
// coordinates); one matching position_code scales signed x and y to the canvas
// (x*area_x/span_x + gap, area_y - y*area_y/span_y + gap, truncation toward
// zero, saturated to 18 bits). a byte that starts no frame work leaves the
// block idle and ready for the next byte. after a reply frame the next byte is
// taken once the output state has loaded the reply beat. after a position
// frame it is taken once the block has passed the multiply state, the divider
// load state, the wait state while the two 28-step bit-serial dividers run
// side by side and finish, and the output state. a full output register that
// is not drained adds its wait on top; otherwise the output register lets a
// finished beat wait while the next bytes come in. configuration writes are
// taken at any time and must only be made while idle; a span of zero divides as one.
module position_packet_deframer
	import ppd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                result_kind,
	output logic signed [17:0]  point_x,
	output logic signed [17:0]  point_y,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	localparam int SumW = 30;

	// configuration registers
	logic [14:0] span_x_q;
	logic [14:0] span_y_q;
	logic [11:0] area_x_q;
	logic [11:0] area_y_q;
	logic [9:0]  border_gap_q;
	logic [7:0]  reply_code_q;
	logic [7:0]  position_code_q;

	logic [2:0]  state_q;
	logic        in_beat;

	// window row
	byte_t       win [WinDepth];
	byte_t       win_d [WinDepth];

	logic [15:0] sum;
	logic [15:0] check;
	logic        frame_ok;

	logic               kind_q;
	logic signed [15:0] x_q;
	logic signed [15:0] y_q;
	logic signed [28:0] px_full;
	logic signed [28:0] py_full;
	logic signed [27:0] prod_x_s1;
	logic signed [27:0] prod_y_s1;
	logic               neg_x_q;
	logic               neg_y_q;

	logic        div_start;
	logic        div_busy_x;
	logic        div_busy_y;
	mag_t        mag_x;
	mag_t        mag_y;
	mag_t        quo_x;
	mag_t        quo_y;
	dvs_t        dvs_x;
	dvs_t        dvs_y;

	logic signed [SumW-1:0] qx_s;
	logic signed [SumW-1:0] qy_s;
	logic signed [SumW-1:0] px_sum;
	logic signed [SumW-1:0] py_sum;

	logic                   out_valid_q;
	logic                   out_kind_q;
	logic signed [OutW-1:0] out_x_q;
	logic signed [OutW-1:0] out_y_q;
	logic                   out_load;

	function automatic logic signed [OutW-1:0] sat18(input logic signed [SumW-1:0] v);
		logic signed [SumW-1:0] hi;
		logic signed [SumW-1:0] lo;
		hi = SumW'(131071);
		lo = -SumW'(131072);
		if (v > hi) begin
			sat18 = OutW'(hi);
		end else if (v < lo) begin
			sat18 = OutW'(lo);
		end else begin
			sat18 = v[OutW-1:0];
		end
	endfunction

	assign cfg_ready = 1'b1;
	assign in_ready  = state_q == ST_IDLE;
	assign in_beat   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_x_q        <= 15'd1;
			span_y_q        <= 15'd1;
			area_x_q        <= 12'd512;
			area_y_q        <= 12'd512;
			border_gap_q    <= 10'd0;
			reply_code_q    <= 8'd1;
			position_code_q <= 8'd2;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SPAN_X:        span_x_q        <= cfg_data[14:0];
				CFG_SPAN_Y:        span_y_q        <= cfg_data[14:0];
				CFG_AREA_X:        area_x_q        <= cfg_data[11:0];
				CFG_AREA_Y:        area_y_q        <= cfg_data[11:0];
				CFG_BORDER_GAP:    border_gap_q    <= cfg_data[9:0];
				CFG_REPLY_CODE:    reply_code_q    <= cfg_data[7:0];
				CFG_POSITION_CODE: position_code_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// row of cells, oldest byte in cell 0, new byte enters the last cell
	genvar gi;
	generate
		for (gi = 0; gi < WinDepth; gi++) begin : g_cell
			if (gi == WinDepth - 1) begin : g_last
				assign win_d[gi] = rx_byte;
			end else begin : g_mid
				assign win_d[gi] = win[gi+1];
			end
			ppd_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (in_beat),
				.d      (win_d[gi]),
				.q      (win[gi])
			);
		end
	endgenerate

	// frame check over the window as it stands with the new byte
	always_comb begin
		sum = '0;
		for (int i = 0; i < SumBytes; i++) begin
			sum = sum + {8'd0, win[i]};
		end
	end

	assign check    = {win[WinDepth-1], rx_byte};
	assign frame_ok = win[0] == HDR_FIRST && win[1] == HDR_SECOND && sum == check;

	// control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat && frame_ok) begin
						if (win[3] == reply_code_q) begin
							state_q <= ST_OUT;
						end else if (win[3] == position_code_q) begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL:  state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (!div_busy_x && !div_busy_y) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// frame fields caught on the accepting beat
	always_ff @(posedge clk) begin
		if (in_beat) begin
			kind_q <= win[3] != reply_code_q;
			x_q    <= {win[4], win[5]};
			y_q    <= {win[6], win[7]};
		end
	end

	// multiply state, products stay within 28 signed bits
	assign px_full = x_q * $signed({1'b0, area_x_q});
	assign py_full = y_q * $signed({1'b0, area_y_q});

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_x_s1 <= px_full[27:0];
			prod_y_s1 <= py_full[27:0];
		end
	end

	// divide magnitudes, sign goes back on afterwards for truncation toward zero
	assign mag_x = prod_x_s1[27] ? mag_t'(-prod_x_s1) : mag_t'(prod_x_s1);
	assign mag_y = prod_y_s1[27] ? mag_t'(-prod_y_s1) : mag_t'(prod_y_s1);
	assign dvs_x = (span_x_q == '0) ? DivW'(1) : span_x_q;
	assign dvs_y = (span_y_q == '0) ? DivW'(1) : span_y_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			neg_x_q <= prod_x_s1[27];
			neg_y_q <= prod_y_s1[27];
		end
	end

	assign div_start = state_q == ST_LOAD;

	ppd_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_x),
		.divisor  (dvs_x),
		.busy     (div_busy_x),
		.quotient (quo_x)
	);

	ppd_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_y),
		.divisor  (dvs_y),
		.busy     (div_busy_y),
		.quotient (quo_y)
	);

	// final offset and saturation
	assign qx_s   = neg_x_q ? -$signed({2'b00, quo_x}) : $signed({2'b00, quo_x});
	assign qy_s   = neg_y_q ? -$signed({2'b00, quo_y}) : $signed({2'b00, quo_y});
	assign px_sum = qx_s + $signed({20'd0, border_gap_q});
	assign py_sum = $signed({18'd0, area_y_q}) - qy_s
	                + $signed({20'd0, border_gap_q});

	// output register, loads when empty or being drained
	assign out_load = state_q == ST_OUT && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= kind_q;
			out_x_q    <= kind_q ? sat18(px_sum) : '0;
			out_y_q    <= kind_q ? sat18(py_sum) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign point_x     = out_x_q;
	assign point_y     = out_y_q;

endmodule

@@ rtl/ppd_cell.sv @@
module ppd_cell
	import ppd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  byte_t d,
	output byte_t q
);

	byte_t byte_q;

	// one window slot, takes its younger neighbor's byte on each shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

@@ rtl/ppd_div.sv @@
module ppd_div
	import ppd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  mag_t     dividend,
	input  dvs_t     divisor,
	output logic     busy,
	output mag_t     quotient
);

	mag_t            dvd_q;
	dvs_t            dvs_q;
	dvs_t            rem_q;
	logic [CntW-1:0] cnt_q;
	logic [DivW:0]   shifted;
	logic [DivW:0]   diff;
	logic            ge;

	// restoring division, one quotient bit per cycle
	assign shifted = {rem_q, dvd_q[MagW-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(MagW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[MagW-2:0], ge};
			rem_q <= ge ? diff[DivW-1:0] : shifted[DivW-1:0];
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = dvd_q;

endmodule

@@ sim/tb_position_packet_deframer.sv @@
module tb_position_packet_deframer
	import ppd_pkg::*;
;

	// index past the register list, the block must ignore it
	localparam logic [2:0] CFG_SPARE = 3'd7;

	localparam logic KIND_REPLY = 1'b0;
	localparam logic KIND_POINT = 1'b1;

	localparam int FrameLen     = WinDepth + 1;
	localparam int PhaseBytes   = 85;
	localparam int SettleCycles = 64;
	localparam int StallLimit   = 4000;
	localparam int MaxShown     = 10;

	localparam longint PointMax = (longint'(1) << (OutW - 1)) - 1;
	localparam longint PointMin = -PointMax - 1;

	typedef struct {
		logic                   kind;
		logic signed [OutW-1:0] x;
		logic signed [OutW-1:0] y;
	} point_t;

	// clock, reset and block ports
	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic [7:0]             rx_byte = '0;
	logic                   out_ready = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic [2:0]             cfg_index = '0;
	logic [31:0]            cfg_data = '0;
	logic                   in_ready;
	logic                   out_valid;
	logic                   result_kind;
	logic signed [OutW-1:0] point_x;
	logic signed [OutW-1:0] point_y;
	logic                   cfg_ready;

	position_packet_deframer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_kind(result_kind),
		.point_x    (point_x),
		.point_y    (point_y),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	// own copy of the registers and of the byte window
	logic [14:0] span_x_r;
	logic [14:0] span_y_r;
	logic [11:0] area_x_r;
	logic [11:0] area_y_r;
	logic [9:0]  gap_r;
	byte_t       reply_code_r;
	byte_t       position_code_r;
	byte_t       window_r [WinDepth];

	byte_t  tx_bytes [$];          // bytes waiting for the driver
	point_t pending_points [$];    // results predicted but not yet seen
	point_t want;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit byte_taken = 1'b0;
	int bytes_queued = 0;
	int bytes_sent = 0;
	int replies_seen = 0;
	int points_seen = 0;
	int reg_writes = 0;
	int errors = 0;
	int stall_cycles = 0;

	function automatic logic signed [OutW-1:0] saturate_point(longint v);
		if (v > PointMax)
			return PointMax[OutW-1:0];
		if (v < PointMin)
			return PointMin[OutW-1:0];
		return v[OutW-1:0];
	endfunction

	// shift one byte into the window and predict what the ten-byte window yields
	function automatic void deframe_byte(byte_t b);
		byte_t                w [FrameLen];
		logic [15:0]          sum;
		logic signed [15:0]   xs;
		logic signed [15:0]   ys;
		longint               dx;
		longint               dy;
		longint               px;
		longint               py;
		point_t               p;
		for (int i = 0; i < WinDepth; i++)
			w[i] = window_r[i];
		w[WinDepth] = b;
		for (int i = 0; i < WinDepth; i++)
			window_r[i] = w[i + 1];
		if (w[0] != HDR_FIRST || w[1] != HDR_SECOND)
			return;
		sum = '0;
		for (int i = 0; i < SumBytes; i++)
			sum += w[i];
		if (sum != {w[8], w[9]})
			return;
		// reply wins when both codes are equal
		if (w[3] == reply_code_r) begin
			p.kind = KIND_REPLY;
			p.x = '0;
			p.y = '0;
			pending_points.push_back(p);
		end else if (w[3] == position_code_r) begin
			xs = {w[4], w[5]};
			ys = {w[6], w[7]};
			// a zero span divides as one
			dx = (span_x_r == 0) ? 1 : longint'(span_x_r);
			dy = (span_y_r == 0) ? 1 : longint'(span_y_r);
			px = (longint'(xs) * longint'(area_x_r)) / dx + longint'(gap_r);
			py = longint'(area_y_r) - (longint'(ys) * longint'(area_y_r)) / dy
				+ longint'(gap_r);
			p.kind = KIND_POINT;
			p.x = saturate_point(px);
			p.y = saturate_point(py);
			pending_points.push_back(p);
		end
	endfunction

	function automatic void push_byte(byte_t b);
		tx_bytes.push_back(b);
		bytes_queued++;
	endfunction

	// full ten-byte frame, checksum optionally broken in one bit
	function automatic void queue_frame(byte_t cmd, logic [15:0] x, logic [15:0] y,
			bit bad_sum);
		byte_t       f [FrameLen];
		logic [15:0] sum;
		f[0] = HDR_FIRST;
		f[1] = HDR_SECOND;
		f[2] = byte_t'($urandom);
		f[3] = cmd;
		f[4] = x[15:8];
		f[5] = x[7:0];
		f[6] = y[15:8];
		f[7] = y[7:0];
		sum = '0;
		for (int i = 0; i < SumBytes; i++)
			sum += f[i];
		if (bad_sum)
			sum ^= 16'(1 << $urandom_range(15));
		f[8] = sum[15:8];
		f[9] = sum[7:0];
		foreach (f[i])
			push_byte(f[i]);
	endfunction

	function automatic logic [15:0] any_coord();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic byte_t any_command();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return reply_code_r;
		if (roll < 85)
			return position_code_r;
		return byte_t'($urandom);
	endfunction

	// mostly good frames, some noise, bad sums and cut-off headers
	function automatic void queue_random_segment();
		case ($urandom_range(9))
			0: begin
				repeat ($urandom_range(1, 5))
					push_byte(byte_t'($urandom));
			end
			1: queue_frame(any_command(), any_coord(), any_coord(), 1'b1);
			2: begin
				// header start that never completes, then a real frame
				push_byte(HDR_FIRST);
				if ($urandom_range(1)) begin
					push_byte(HDR_SECOND);
					repeat ($urandom_range(4))
						push_byte(byte_t'($urandom));
				end
				queue_frame(any_command(), any_coord(), any_coord(), 1'b0);
			end
			default: queue_frame(any_command(), any_coord(), any_coord(), 1'b0);
		endcase
	endfunction

	// one register write, random upper data bits to check the masking
	task automatic write_reg(logic [2:0] index, logic [31:0] value, int width);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= (32'($urandom) << width) | value;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		case (cfg_index)
			CFG_SPAN_X:        span_x_r        = cfg_data[14:0];
			CFG_SPAN_Y:        span_y_r        = cfg_data[14:0];
			CFG_AREA_X:        area_x_r        = cfg_data[11:0];
			CFG_AREA_Y:        area_y_r        = cfg_data[11:0];
			CFG_BORDER_GAP:    gap_r           = cfg_data[9:0];
			CFG_REPLY_CODE:    reply_code_r    = cfg_data[7:0];
			CFG_POSITION_CODE: position_code_r = cfg_data[7:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_registers(logic [14:0] ml, logic [14:0] mw, logic [11:0] cl,
			logic [11:0] cw, logic [9:0] gap, byte_t rc, byte_t pc);
		write_reg(CFG_SPAN_X, ml, 15);
		write_reg(CFG_SPAN_Y, mw, 15);
		write_reg(CFG_AREA_X, cl, 12);
		write_reg(CFG_AREA_Y, cw, 12);
		write_reg(CFG_BORDER_GAP, gap, 10);
		write_reg(CFG_REPLY_CODE, rc, 8);
		write_reg(CFG_POSITION_CODE, pc, 8);
	endtask

	// byte driver: new beat only once the previous one is taken
	always @(negedge clk) begin
		if (!in_valid || byte_taken) begin
			byte_taken = 1'b0;
			if (tx_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				rx_byte  <= tx_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor: accepted bytes feed the predictor, result beats are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				deframe_byte(rx_byte);
				byte_taken = 1'b1;
				bytes_sent++;
			end
			if (out_valid && out_ready) begin
				if (pending_points.size() == 0) begin
					errors++;
					if (errors <= MaxShown)
						$display("unexpected result beat: kind %0d x %0d y %0d",
							result_kind, point_x, point_y);
				end else begin
					want = pending_points.pop_front();
					if (want.kind == KIND_REPLY)
						replies_seen++;
					else
						points_seen++;
					if (result_kind !== want.kind || point_x !== want.x
							|| point_y !== want.y) begin
						errors++;
						if (errors <= MaxShown)
							$display("mismatch: expected kind %0d x %0d y %0d, got kind %0d x %0d y %0d",
								want.kind, want.x, want.y, result_kind, point_x, point_y);
					end
				end
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles == StallLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		// reset values of the registers, window starts cleared
		span_x_r        = 15'd1;
		span_y_r        = 15'd1;
		area_x_r        = 12'd512;
		area_y_r        = 12'd512;
		gap_r           = 10'd0;
		reply_code_r    = 8'd1;
		position_code_r = 8'd2;
		foreach (window_r[i])
			window_r[i] = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int phase = 0; phase < 6; phase++) begin
			case (phase / 2)
				0: begin
					send_idle_pct = 10;
					recv_idle_pct = 58;
				end
				1: begin
					send_idle_pct = 58;
					recv_idle_pct = 10;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase

			case (phase)
				0: begin
					// reset settings: frame as the very first bytes, coordinate extremes,
					// other command, broken checksum, stray header byte before a frame
					queue_frame(reply_code_r, 16'h0000, 16'h0000, 1'b0);
					queue_frame(position_code_r, 16'h8000, 16'h7FFF, 1'b0);
					queue_frame(position_code_r, 16'h7FFF, 16'h8000, 1'b0);
					queue_frame(position_code_r, 16'h0064, 16'hFF9C, 1'b0);
					queue_frame(8'hFF, 16'h1234, 16'h5678, 1'b0);
					queue_frame(reply_code_r, 16'h0000, 16'h0000, 1'b1);
					push_byte(HDR_FIRST);
					queue_frame(position_code_r, 16'h0123, 16'hFEDC, 1'b0);
				end
				1: begin
					// zero spans, largest canvas and gap
					set_registers(15'd0, 15'd0, 12'd4095, 12'd4095, 10'd1023, 8'hFF, 8'h00);
					write_reg(CFG_SPARE, 32'($urandom), 0);
				end
				2: begin
					// largest spans, empty canvas, reply and position codes equal
					reply_code_r = byte_t'($urandom);
					set_registers(15'd32767, 15'd32767, 12'd0, 12'd0, 10'd0,
						reply_code_r, reply_code_r);
				end
				4: set_registers(15'd1, 15'd32767, 12'd4095, 12'd1, 10'($urandom_range(1023)),
					8'h5E, 8'h0C);
				5: set_registers(15'($urandom_range(1, 64)), 15'($urandom_range(1, 64)),
					12'($urandom_range(4095)), 12'($urandom_range(4095)),
					10'($urandom_range(1023)), byte_t'($urandom), byte_t'($urandom));
				default: set_registers(15'($urandom_range(32767)), 15'($urandom_range(32767)),
					12'($urandom_range(4095)), 12'($urandom_range(4095)),
					10'($urandom_range(1023)), byte_t'($urandom), byte_t'($urandom));
			endcase

			begin : fill
				int goal;
				goal = bytes_queued + PhaseBytes;
				while (bytes_queued < goal)
					queue_random_segment();
			end

			// drain, then let a frame without a result finish before new settings
			while (tx_bytes.size() != 0 || in_valid || pending_points.size() != 0)
				@(posedge clk);
			repeat (SettleCycles) @(posedge clk);
		end

		if (pending_points.size() != 0) begin
			errors += pending_points.size();
			$display("%0d expected results never arrived", pending_points.size());
		end
		$display("sent %0d bytes over 6 settings and 3 stall patterns, %0d register writes",
			bytes_sent, reg_writes);
		$display("checked %0d reply beats and %0d position beats, %0d errors",
			replies_seen, points_seen, errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
